// ===== rtl/plfm_pkg.sv =====
// ----------------------------------------------------------------------------
// plfm_pkg
// shared types and codes for the price level fifo matcher
// ----------------------------------------------------------------------------
package plfm_pkg;

    localparam int unsigned QTY_W   = 32;
    localparam int unsigned ID_W    = 32;
    localparam int unsigned TOT_W   = 37;
    localparam int unsigned SLOT_W  = 5;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_CANCEL = 2'd1,
        KIND_MATCH  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        RK_ADD_ACK    = 2'd0,
        RK_CANCEL_ACK = 2'd1,
        RK_FILL       = 2'd2,
        RK_DONE       = 2'd3
    } rkind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2,
        ST_SPARE   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALIGN,
        S_WALK,
        S_FREE,
        S_DONE,
        S_OUT
    } state_t;

    // one cell of the ring
    typedef struct packed {
        logic             active;
        logic [ID_W-1:0]  id;
        logic [QTY_W-1:0] remaining;
        logic [QTY_W-1:0] filled;
    } cell_t;

    typedef struct packed {
        logic [1:0]        result_kind;
        logic [1:0]        status;
        logic [SLOT_W-1:0] entry_slot;
        logic [ID_W-1:0]   resting_id;
        logic [QTY_W-1:0]  fill_quantity;
        logic [QTY_W-1:0]  entry_filled_total;
        logic [QTY_W-1:0]  leftover;
        logic [QTY_W-1:0]  incoming_filled;
        logic [TOT_W-1:0]  level_total;
        logic              last;
    } result_t;

endpackage

// ===== rtl/price_level_fifo_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// price_level_fifo_matcher_unit
// one price level of an order book as a fifo ring of resting orders
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one request per transfer: add, cancel or match.
//   m_axis carries the results; tlast marks the final result of a request.
//   the ring is a chain of cells that rotates one position per cycle in
//   align and walk; a rotation offset tracks which cell holds logical slot 0.
//   add and ignored cancel: the result is valid in the cycle after the transfer.
//   cancel: the entry is cleared at the transfer, S_FREE then frees inactive
//   head entries one per cycle and S_DONE presents the staged ack.
//   match: the chain first rotates until the head sits in cell 0, then
//   steps once per occupied entry; an entry with quantity left is first
//   filled in cell 0, which waits for the receiver; head cleanup walks
//   freed entries one per cycle and a done result follows.
//   one request is in flight at a time; s_axis_tready is low while busy
//   and returns after the final result transfer.
//   reset clears valid flags, head, tail, count and the level total.
//   a stalled receiver holds the output register and holds the walk at a fill.
// ----------------------------------------------------------------------------
module price_level_fifo_matcher_unit
#(
    parameter int RING_DEPTH = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // kind[1:0]
    input  logic [1:0]   s_axis_tuser,
    // order_id[31:0], slot[36:32], quantity[68:37], zero pad
    input  logic [71:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_kind[1:0]
    output logic [1:0]   m_axis_tuser,
    // status[1:0], entry_slot[6:2], resting_id[38:7], fill_quantity[70:39],
    // entry_filled_total[102:71], leftover[134:103], incoming_filled[166:135],
    // level_total[203:167], zero pad
    output logic [207:0] m_axis_tdata,
    output logic         m_axis_tlast
);
    import plfm_pkg::*;

    localparam int IW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);

    // input fields
    kind_t             in_kind;
    logic [ID_W-1:0]   in_id;
    logic [SLOT_W-1:0] in_slot;
    logic [QTY_W-1:0]  in_qty;
    assign in_kind = kind_t'(s_axis_tuser);
    assign in_id   = s_axis_tdata[31:0];
    assign in_slot = s_axis_tdata[36:32];
    assign in_qty  = s_axis_tdata[68:37];

    state_t state_reg, state_next;
    // offset: physical cell 0 holds logical slot off_reg
    logic [IW-1:0]    off_reg, off_next;
    logic [IW-1:0]    head_reg, head_next;
    logic [IW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [TOT_W-1:0] tot_reg, tot_next;
    logic [CW-1:0]    step_reg, step_next;   // entries walked in this match
    logic [QTY_W-1:0] left_reg, left_next;
    logic [QTY_W-1:0] qty_reg, qty_next;
    logic             out_v_reg, out_v_next;
    result_t          out_reg, out_next;
    logic             is_match_reg;          // request in flight is a match

    // chain of cells
    cell_t cells [RING_DEPTH];
    logic  rotate;
    logic  load_any;
    logic [IW-1:0] load_phys;
    cell_t load_val;

    genvar g;
    generate
        for (g = 0; g < RING_DEPTH; g++)
        begin : g_cell
            plfm_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .rotate    (rotate),
                .from_prev (cells[(g + 1) % RING_DEPTH]),
                .load      (load_any && (load_phys == IW'(g))),
                .load_val  (load_val),
                .q         (cells[g])
            );
        end
    endgenerate

    // physical index of a logical slot: slot - off (mod depth)
    function automatic logic [IW-1:0] to_phys(input logic [IW-1:0] s,
                                              input logic [IW-1:0] o);
        logic [IW:0] d;
        begin
            d = {1'b0, s} + (IW+1)'(RING_DEPTH) - {1'b0, o};
            if (d >= (IW+1)'(RING_DEPTH))
            begin
                d = d - (IW+1)'(RING_DEPTH);
            end
            return d[IW-1:0];
        end
    endfunction

    function automatic logic [IW-1:0] inc(input logic [IW-1:0] v);
        begin
            return (v == LAST_IDX) ? '0 : v + 1'b1;
        end
    endfunction

    // cell 0 is always at logical slot off_reg during a walk
    cell_t head_cell;
    assign head_cell = cells[0];

    logic             slot_in_ring;
    logic [IW-1:0]    cancel_phys;
    logic [IW-1:0]    head_phys;
    cell_t            cancel_cell;
    cell_t            hc_cell;
    logic [QTY_W-1:0] fill_q;

    assign slot_in_ring = ({{(IW+1 > SLOT_W ? IW+1-SLOT_W : 0){1'b0}}, in_slot} <
                           (IW+1 > SLOT_W ? IW+1 : SLOT_W)'(RING_DEPTH));
    assign cancel_phys  = to_phys(IW'(in_slot), off_reg);
    assign cancel_cell  = cells[cancel_phys];
    assign head_phys    = to_phys(head_reg, off_reg);
    assign hc_cell      = cells[head_phys];
    assign fill_q       = (head_cell.remaining < left_reg) ? head_cell.remaining : left_reg;

    assign s_axis_tready = (state_reg == S_IDLE) && !out_v_reg;

    always_comb
    begin
        state_next = state_reg;
        off_next   = off_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        cnt_next   = cnt_reg;
        tot_next   = tot_reg;
        step_next  = step_reg;
        left_next  = left_reg;
        qty_next   = qty_reg;
        out_v_next = out_v_reg;
        out_next   = out_reg;
        rotate     = 1'b0;
        load_any   = 1'b0;
        load_phys  = '0;
        load_val   = cancel_cell;

        if (out_v_reg && m_axis_tready)
        begin
            out_v_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    out_next = '0;
                    out_next.last = 1'b1;
                    case (in_kind)
                        KIND_ADD:
                        begin
                            out_v_next = 1'b1;
                            out_next.result_kind = RK_ADD_ACK;
                            if (in_qty == '0)
                            begin
                                out_next.status = ST_IGNORED;
                                out_next.level_total = tot_reg;
                            end
                            else if (cnt_reg >= CW'(RING_DEPTH))
                            begin
                                out_next.status = ST_FULL;
                                out_next.level_total = tot_reg;
                            end
                            else
                            begin
                                load_any  = 1'b1;
                                load_phys = to_phys(tail_reg, off_reg);
                                load_val.active    = 1'b1;
                                load_val.id        = in_id;
                                load_val.remaining = in_qty;
                                load_val.filled    = '0;
                                tail_next = inc(tail_reg);
                                cnt_next  = cnt_reg + 1'b1;
                                tot_next  = tot_reg + TOT_W'(in_qty);
                                out_next.status     = ST_OK;
                                out_next.entry_slot = SLOT_W'(tail_reg);
                                out_next.resting_id = in_id;
                                out_next.level_total = tot_reg + TOT_W'(in_qty);
                            end
                        end
                        KIND_CANCEL:
                        begin
                            out_next.result_kind = RK_CANCEL_ACK;
                            out_next.entry_slot  = in_slot;
                            if (!slot_in_ring || !cancel_cell.active)
                            begin
                                out_v_next = 1'b1;
                                out_next.status = ST_IGNORED;
                                out_next.level_total = tot_reg;
                            end
                            else
                            begin
                                load_any  = 1'b1;
                                load_phys = cancel_phys;
                                load_val.active = 1'b0;
                                tot_next = tot_reg - TOT_W'(cancel_cell.remaining);
                                out_next.status = ST_OK;
                                out_next.resting_id = cancel_cell.id;
                                out_next.entry_filled_total = cancel_cell.filled;
                                state_next = S_FREE;
                            end
                        end
                        KIND_MATCH:
                        begin
                            left_next  = in_qty;
                            qty_next   = in_qty;
                            step_next  = '0;
                            state_next = S_ALIGN;
                        end
                        default:
                        begin
                            out_next = out_reg;
                        end
                    endcase
                end
            end

            // bring the head entry into cell 0 so the walk runs in ring order
            S_ALIGN:
            begin
                if (off_reg == head_reg)
                begin
                    state_next = S_WALK;
                end
                else
                begin
                    rotate   = 1'b1;
                    off_next = inc(off_reg);
                end
            end

            // cell 0 holds logical slot off_reg; rotate one step per entry
            S_WALK:
            begin
                if (step_reg == cnt_reg || left_reg == '0)
                begin
                    state_next = S_FREE;
                end
                else if (head_cell.active && head_cell.remaining != '0)
                begin
                    if (!out_v_reg || m_axis_tready)
                    begin
                        load_val = head_cell;
                        load_val.remaining = head_cell.remaining - fill_q;
                        load_val.filled    = head_cell.filled + fill_q;
                        load_val.active    = (head_cell.remaining != fill_q);
                        load_any  = 1'b1;
                        load_phys = '0;
                        left_next = left_reg - fill_q;
                        tot_next  = tot_reg - TOT_W'(fill_q);
                        out_v_next = 1'b1;
                        out_next = '0;
                        out_next.result_kind = RK_FILL;
                        out_next.status      = ST_OK;
                        out_next.entry_slot  = SLOT_W'(off_reg);
                        out_next.resting_id  = head_cell.id;
                        out_next.fill_quantity = fill_q;
                        out_next.entry_filled_total = head_cell.filled + fill_q;
                        out_next.level_total = tot_reg - TOT_W'(fill_q);
                        out_next.last = 1'b0;
                    end
                end
                else
                begin
                    rotate    = 1'b1;
                    off_next  = inc(off_reg);
                    step_next = step_reg + 1'b1;
                end
            end

            // free inactive entries at the head, one per cycle
            S_FREE:
            begin
                if (cnt_reg != '0 && !hc_cell.active)
                begin
                    head_next = inc(head_reg);
                    cnt_next  = cnt_reg - 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // a cancel ack is already staged in out_reg; a match builds done
            S_DONE:
            begin
                if (!out_v_reg || m_axis_tready)
                begin
                    out_v_next = 1'b1;
                    if (is_match_reg)
                    begin
                        out_next = '0;
                        out_next.result_kind = RK_DONE;
                        out_next.status = (qty_reg == '0) ? ST_IGNORED : ST_OK;
                        out_next.leftover = left_reg;
                        out_next.incoming_filled = qty_reg - left_reg;
                        out_next.last = 1'b1;
                    end
                    out_next.level_total = tot_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            off_reg      <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            cnt_reg      <= '0;
            tot_reg      <= '0;
            step_reg     <= '0;
            out_v_reg    <= 1'b0;
            is_match_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            off_reg   <= off_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cnt_reg   <= cnt_next;
            tot_reg   <= tot_next;
            step_reg  <= step_next;
            out_v_reg <= out_v_next;
            if (state_reg == S_IDLE && s_axis_tvalid && s_axis_tready)
            begin
                is_match_reg <= (in_kind == KIND_MATCH);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg <= left_next;
        qty_reg  <= qty_next;
        out_reg  <= out_next;
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tuser  = out_reg.result_kind;
    assign m_axis_tdata  = {4'b0000, out_reg.level_total, out_reg.incoming_filled,
                            out_reg.leftover, out_reg.entry_filled_total,
                            out_reg.fill_quantity, out_reg.resting_id,
                            out_reg.entry_slot, out_reg.status};

endmodule

// ===== rtl/plfm_cell.sv =====
// ----------------------------------------------------------------------------
// plfm_cell
// one ring entry; load from the input, or take the neighbor's entry on rotate
// ----------------------------------------------------------------------------
module plfm_cell
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rotate,
    input  plfm_pkg::cell_t  from_prev,
    input  logic             load,
    input  plfm_pkg::cell_t  load_val,
    output plfm_pkg::cell_t  q
);
    import plfm_pkg::*;

    cell_t            cell_next;
    logic             active_reg;
    logic [ID_W-1:0]  id_reg;
    logic [QTY_W-1:0] remaining_reg;
    logic [QTY_W-1:0] filled_reg;

    assign q = {active_reg, id_reg, remaining_reg, filled_reg};

    always_comb
    begin
        cell_next = q;
        if (rotate)
        begin
            cell_next = from_prev;
        end
        else if (load)
        begin
            cell_next = load_val;
        end
    end

    // only active needs reset; payload is don't care until written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= cell_next.active;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg        <= cell_next.id;
        remaining_reg <= cell_next.remaining;
        filled_reg    <= cell_next.filled;
    end

endmodule

// ===== rtl/plfm_checker.sv =====
// ----------------------------------------------------------------------------
// plfm_checker
// port-level checks for the price level fifo matcher
// ----------------------------------------------------------------------------
module plfm_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [1:0]   m_axis_tuser,
    input logic [207:0] m_axis_tdata,
    input logic         m_axis_tlast
);
    import plfm_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable({m_axis_tuser, m_axis_tdata, m_axis_tlast}))
        else $error("result changed under stall");

    // no new request while a result waits
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("ready while result pending");

    // fills never end a request, acks and done always do
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != RK_FILL)))
        else $error("tlast mismatch");

    // a fill is never zero
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == RK_FILL |-> m_axis_tdata[70:39] != '0)
        else $error("zero fill");

endmodule

bind price_level_fifo_matcher_unit plfm_checker u_plfm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/tb_price_level_fifo_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// tb_price_level_fifo_matcher_unit
// self-checking bench for one price level matcher ring
// ----------------------------------------------------------------------------
// drives add, cancel and match requests on s_axis with random gaps, predicts
// every result of the ring in a scoreboard class and checks m_axis transfers
// field by field in arrival order; includes a long receiver hold-off so the
// block backs up, and a sender pause that drains all pending results
// ----------------------------------------------------------------------------
module tb_price_level_fifo_matcher_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import plfm_pkg::*;

    localparam int DEPTH = 32;
    localparam int N_RANDOM = 390;
    localparam longint CYCLE_LIMIT = 2000000;

    // one predicted or observed result
    typedef struct packed {
        rkind_t             rk;
        status_t            st;
        logic [SLOT_W-1:0]  slot;
        logic [ID_W-1:0]    rid;
        logic [QTY_W-1:0]   fq;
        logic [QTY_W-1:0]   eft;
        logic [QTY_W-1:0]   lo;
        logic [QTY_W-1:0]   inf;
        logic [TOT_W-1:0]   total;
        logic               last;
    } book_result_t;

    int errors = 0;
    int fills_seen = 0;
    int fulls_seen = 0;

    task automatic report(input string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    // ring predictor plus the queue of pending results
    class level_book;
        logic [ID_W-1:0]  ids [DEPTH];
        logic [QTY_W-1:0] rem [DEPTH];
        logic [QTY_W-1:0] filled [DEPTH];
        bit               act [DEPTH];
        int               head, tail, count;
        logic [TOT_W-1:0] total;
        book_result_t     pending [$];

        function new();
            head = 0; tail = 0; count = 0; total = '0;
            foreach (act[i]) act[i] = 0;
        endfunction

        function void push(book_result_t r);
            r.total = total;
            pending.push_back(r);
        endfunction

        function void free_head();
            while (count > 0 && !act[head])
            begin
                head = (head + 1) % DEPTH;
                count--;
            end
        endfunction

        // predict the results of one accepted request
        function void note_request(kind_t k, logic [31:0] oid, logic [4:0] s,
                                   logic [31:0] q);
            book_result_t r;
            logic [31:0] left, f;
            int i;
            r = '0;
            r.last = 1;
            case (k)
                KIND_ADD:
                begin
                    r.rk = RK_ADD_ACK;
                    if (q == 0) r.st = ST_IGNORED;
                    else if (count >= DEPTH) r.st = ST_FULL;
                    else
                    begin
                        ids[tail] = oid; rem[tail] = q; filled[tail] = 0;
                        act[tail] = 1;
                        r.slot = 5'(tail); r.rid = oid;
                        tail = (tail + 1) % DEPTH;
                        count++;
                        total = total + q;
                    end
                    push(r);
                end
                KIND_CANCEL:
                begin
                    r.rk = RK_CANCEL_ACK;
                    r.slot = s;
                    if (!act[s]) r.st = ST_IGNORED;
                    else
                    begin
                        act[s] = 0;
                        total = total - rem[s];
                        free_head();
                        r.rid = ids[s]; r.eft = filled[s];
                    end
                    push(r);
                end
                KIND_MATCH:
                begin
                    left = q;
                    i = head;
                    for (int c = 0; c < count && left > 0; c++)
                    begin
                        if (act[i] && rem[i] > 0)
                        begin
                            f = (rem[i] < left) ? rem[i] : left;
                            rem[i] -= f; filled[i] += f; left -= f;
                            total = total - f;
                            if (rem[i] == 0) act[i] = 0;
                            r = '0;
                            r.rk = RK_FILL; r.slot = 5'(i); r.rid = ids[i];
                            r.fq = f; r.eft = filled[i];
                            push(r);
                        end
                        i = (i + 1) % DEPTH;
                    end
                    free_head();
                    r = '0;
                    r.rk = RK_DONE;
                    r.st = (q == 0) ? ST_IGNORED : ST_OK;
                    r.lo = left; r.inf = q - left; r.last = 1;
                    push(r);
                end
                default: ;
            endcase
        endfunction

        task check_result(book_result_t got);
            book_result_t exp;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result kind %0d", got.rk));
                return;
            end
            exp = pending.pop_front();
            if (got.rk != exp.rk) report($sformatf("kind %0d exp %0d", got.rk, exp.rk));
            if (got.st != exp.st) report($sformatf("status %0d exp %0d", got.st, exp.st));
            if (got.slot != exp.slot) report($sformatf("slot %0d exp %0d", got.slot, exp.slot));
            if (got.rid != exp.rid) report($sformatf("id %0h exp %0h", got.rid, exp.rid));
            if (got.fq != exp.fq) report($sformatf("fill %0d exp %0d", got.fq, exp.fq));
            if (got.eft != exp.eft) report($sformatf("filled %0d exp %0d", got.eft, exp.eft));
            if (got.lo != exp.lo) report($sformatf("leftover %0d exp %0d", got.lo, exp.lo));
            if (got.inf != exp.inf) report($sformatf("incoming %0d exp %0d", got.inf, exp.inf));
            if (got.total != exp.total)
                report($sformatf("total %0d exp %0d", got.total, exp.total));
            if (got.last != exp.last) report($sformatf("last %0d exp %0d", got.last, exp.last));
        endtask
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [1:0]   s_axis_tuser;
    logic [71:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [1:0]   m_axis_tuser;
    logic [207:0] m_axis_tdata;
    logic         m_axis_tlast;

    level_book book = new();
    longint cycles = 0;
    bit hold_rx = 0;         // long receiver hold-off in progress

    price_level_fifo_matcher_unit #(.RING_DEPTH(DEPTH)) dut (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // cycle counter and timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // send one request, random gap first; note it when the transfer happens
    task automatic send(input kind_t k, input logic [31:0] oid,
                        input logic [4:0] s, input logic [31:0] q);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tuser  <= 2'($urandom);
            s_axis_tdata  <= 72'({$urandom, $urandom, $urandom});
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= k;
        s_axis_tdata  <= {3'b000, q, s, oid};
        do @(posedge clk); while (!s_axis_tready);
        book.note_request(k, oid, s, q);
    endtask

    // random slot among occupied entries most of the time
    function automatic logic [4:0] pick_slot();
        if ($urandom_range(0, 3) != 0 && book.count > 0)
            return 5'((book.head + $urandom_range(0, book.count - 1)) % DEPTH);
        return 5'($urandom_range(0, DEPTH - 1));
    endfunction

    function automatic logic [31:0] rand_qty();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hffff_ffff;
            2: return $urandom;
            default: return $urandom_range(1, 200);
        endcase
    endfunction

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (book.pending.size() != 0) @(posedge clk);
        repeat (2 * DEPTH + 10) @(posedge clk);
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        book_result_t got;
        int gap;
        m_axis_tready = 0;
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(0, 8);
            if ($urandom_range(0, 2) == 0) gap = 0;
            if (gap != 0 || hold_rx)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
                while (hold_rx) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            got.rk    = rkind_t'(m_axis_tuser);
            got.st    = status_t'(m_axis_tdata[1:0]);
            got.slot  = m_axis_tdata[6:2];
            got.rid   = m_axis_tdata[38:7];
            got.fq    = m_axis_tdata[70:39];
            got.eft   = m_axis_tdata[102:71];
            got.lo    = m_axis_tdata[134:103];
            got.inf   = m_axis_tdata[166:135];
            got.total = m_axis_tdata[203:167];
            got.last  = m_axis_tlast;
            if (got.rk == RK_FILL) fills_seen++;
            if (got.rk == RK_ADD_ACK && got.st == ST_FULL) fulls_seen++;
            book.check_result(got);
        end
    end

    initial
    begin
        s_axis_tvalid = 0;
        s_axis_tuser = '0;
        s_axis_tdata = '0;
        rst_n = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty-book cases, then fill the ring to overflow
        send(KIND_CANCEL, 32'd0, 5'd0, 32'd0);
        send(KIND_MATCH, 32'd0, 5'd0, 32'd10);
        send(KIND_MATCH, 32'd0, 5'd0, 32'd0);
        send(KIND_ADD, 32'h1234, 5'd0, 32'd0);
        send(KIND_NONE, 32'hffff_ffff, 5'd31, 32'hffff_ffff);
        send(KIND_ADD, 32'hffff_ffff, 5'd31, 32'hffff_ffff);
        send(KIND_ADD, 32'h0, 5'd0, 32'd1);
        for (int j = 0; j < DEPTH - 2; j++)
            send(KIND_ADD, $urandom, 5'd0, 32'd7);
        send(KIND_ADD, 32'h55, 5'd0, 32'd3);     // ring full
        send(KIND_CANCEL, 32'd0, 5'd5, 32'd0);
        send(KIND_CANCEL, 32'd0, 5'd5, 32'd0);   // already inactive
        send(KIND_MATCH, 32'd0, 5'd0, 32'hffff_ffff);  // fills only the head entry
        send(KIND_MATCH, 32'd0, 5'd0, 32'd0);
        wait_drained();

        // long receiver hold-off while requests keep coming
        fork
        begin
            hold_rx = 1;
            repeat (600) @(posedge clk);
            hold_rx = 0;
        end
        for (int j = 0; j < 20; j++)
            send(j % 3 == 2 ? KIND_MATCH : KIND_ADD, $urandom, 5'd0,
                 $urandom_range(1, 50));
        join

        // random: mostly adds and matches with some cancels and noise
        for (int n = 0; n < N_RANDOM; n++)
        begin
            int r;
            r = $urandom_range(0, 99);
            if (n == N_RANDOM / 2) wait_drained();
            if (r < 45) send(KIND_ADD, $urandom, 5'($urandom), rand_qty());
            else if (r < 65) send(KIND_CANCEL, $urandom, pick_slot(), $urandom);
            else if (r < 97) send(KIND_MATCH, $urandom, 5'($urandom),
                                  $urandom_range(0, 3) == 0 ? rand_qty()
                                                             : $urandom_range(0, 400));
            else send(KIND_NONE, $urandom, 5'($urandom), $urandom);
        end
        s_axis_tvalid <= 1'b0;

        while (book.pending.size() != 0) @(posedge clk);
        repeat (3 * DEPTH + 20) @(posedge clk);
        $display("ran adds, cancels, matches and unknown kinds under random stalls");
        $display("saw %0d fills and %0d ring-full acks", fills_seen, fulls_seen);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/plfm_pkg.sv
rtl/plfm_cell.sv
rtl/price_level_fifo_matcher_unit.sv
rtl/plfm_checker.sv
tb/tb_price_level_fifo_matcher_unit.sv
